// ===== hdl/pida_pkg.sv =====
// ---------------------------------------------------------------------------
// pida_pkg
// Shared types and constants of the process ID allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package pida_pkg;

  // Sizes
  localparam int ID_LIMIT      = 128;
  localparam int TABLE_ENTRIES = 64;
  localparam int ID_W          = 7;                            // given / released ID
  localparam int CAND_W        = ID_W + 1;                     // candidate, bound
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  // Opcodes
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  // Access to the ID table memory
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    logic [ID_W-1:0]   wdata;
  } tbl_req_t;

  // Finished result handed to the output stage
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] given_id;
    logic [1:0]      status;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/pida_table.sv =====
// ---------------------------------------------------------------------------
// pida_table
// Single-port synchronous memory holding the ID of each table slot.
// ---------------------------------------------------------------------------
`default_nettype none

module pida_table (
  input  wire                        clk,
  input  pida_pkg::tbl_req_t         req,
  output logic [pida_pkg::ID_W-1:0]  rd_data
);
  import pida_pkg::*;

  logic [ID_W-1:0] mem [TABLE_ENTRIES];

  // Write on request, registered read every cycle
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rd_data <= mem[req.addr];
  end

endmodule

`default_nettype wire

// ===== hdl/pida_ctrl.sv =====
// ---------------------------------------------------------------------------
// pida_ctrl
// Request sequencer: walks the ID table for the safe-bound scan and for
// release lookups, keeps slot valid bits, live count, last ID and bound.
// ---------------------------------------------------------------------------
`default_nettype none

module pida_ctrl (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        req_valid,
  output logic                       req_ready,
  input  wire                        req_opcode,
  input  wire [pida_pkg::ID_W-1:0]   req_release_id,
  output pida_pkg::tbl_req_t         tbl_req,
  input  wire [pida_pkg::ID_W-1:0]   tbl_rd_data,
  output pida_pkg::res_t             res,
  input  wire                        res_ready
);
  import pida_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]               state;
  logic [TABLE_ENTRIES-1:0] slot_valid;
  logic [CNT_W-1:0]         live_count;
  logic [ID_W-1:0]          last_given;
  logic [CAND_W-1:0]        safe_bound;

  logic                     op;
  logic [ID_W-1:0]          rid;
  logic [CAND_W-1:0]        cand;
  logic [CAND_W-1:0]        bound;
  logic [CNT_W-1:0]         rd_idx;
  logic                     pend_v;
  logic [SLOT_W-1:0]        pend_slot;
  logic                     pend_live;
  logic [ID_W-1:0]          res_id;
  logic [1:0]               res_status;

  logic                     issue_done;
  logic                     table_full;
  logic [CAND_W-1:0]        cand_first;
  logic [CAND_W-1:0]        cand_inc;
  logic [CAND_W-1:0]        entry;
  logic [SLOT_W-1:0]        free_slot;

  assign issue_done = (rd_idx == CNT_W'(TABLE_ENTRIES));
  assign table_full = (live_count >= CNT_W'(TABLE_ENTRIES)) ||
                      ({1'b0, live_count} >= (CNT_W + 1)'(ID_LIMIT - 1));
  assign cand_first = {1'b0, last_given} + CAND_W'(1);
  assign cand_inc   = cand + CAND_W'(1);
  assign entry      = {1'b0, tbl_rd_data};

  // Lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

  // Table port: reads while scanning, one write when an ID is stored
  always_comb begin
    tbl_req.we    = (state == S_WRITE);
    tbl_req.addr  = (state == S_WRITE) ? free_slot : rd_idx[SLOT_W-1:0];
    tbl_req.wdata = cand[ID_W-1:0];
  end

  assign req_ready    = (state == S_IDLE);
  assign res.valid    = (state == S_DONE);
  assign res.given_id = res_id;
  assign res.status   = res_status;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      live_count <= '0;
      last_given <= ID_W'(ID_LIMIT - 1);
      safe_bound <= CAND_W'(ID_LIMIT);
      pend_v     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op     <= req_opcode;
            rid    <= req_release_id;
            rd_idx <= '0;
            pend_v <= 1'b0;
            bound  <= CAND_W'(ID_LIMIT);
            if (req_opcode == OP_RELEASE) begin
              state <= S_SCAN;
            end else if (table_full) begin
              res_id     <= '0;
              res_status <= ST_FULL;
              state      <= S_DONE;
            end else if (cand_first >= CAND_W'(ID_LIMIT)) begin
              // wrap: restart from the lowest ID and rescan
              cand  <= CAND_W'(1);
              state <= S_SCAN;
            end else begin
              cand  <= cand_first;
              state <= (cand_first >= safe_bound) ? S_SCAN : S_WRITE;
            end
          end
        end

        S_SCAN: begin
          // issue next read, pipeline slot info alongside
          pend_v    <= !issue_done;
          pend_slot <= rd_idx[SLOT_W-1:0];
          pend_live <= slot_valid[rd_idx[SLOT_W-1:0]];
          if (!issue_done) begin
            rd_idx <= rd_idx + CNT_W'(1);
          end

          // examine the entry read last cycle
          if (pend_v && pend_live) begin
            if (op == OP_RELEASE) begin
              if (tbl_rd_data == rid) begin
                slot_valid[pend_slot] <= 1'b0;
                live_count            <= live_count - CNT_W'(1);
                res_id                <= '0;
                res_status            <= ST_OK;
                pend_v                <= 1'b0;
                state                 <= S_DONE;
              end
            end else if (entry == cand) begin
              if (cand_inc >= bound) begin
                // candidate ran into the bound: restart the pass
                cand   <= (cand_inc >= CAND_W'(ID_LIMIT)) ? CAND_W'(1) : cand_inc;
                bound  <= CAND_W'(ID_LIMIT);
                rd_idx <= '0;
                pend_v <= 1'b0;
              end else begin
                cand <= cand_inc;
              end
            end else if (entry > cand && bound > entry) begin
              bound <= entry;
            end
          end

          // pass complete
          if (!pend_v && issue_done) begin
            if (op == OP_RELEASE) begin
              res_id     <= '0;
              res_status <= ST_MISS;
              state      <= S_DONE;
            end else begin
              safe_bound <= bound;
              state      <= S_WRITE;
            end
          end
        end

        S_WRITE: begin
          slot_valid[free_slot] <= 1'b1;
          live_count            <= live_count + CNT_W'(1);
          last_given            <= cand[ID_W-1:0];
          res_id                <= cand[ID_W-1:0];
          res_status            <= ST_OK;
          state                 <= S_DONE;
        end

        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/process_id_allocator_core.sv =====
// ---------------------------------------------------------------------------
// process_id_allocator_core
// Allocates and releases unique process IDs from a 64-slot table.
// ---------------------------------------------------------------------------
// One request is worked on at a time. An allocate that stays below the safe
// bound writes its ID without a scan, and one refused when the table is full
// returns status "full"; one that wraps or reaches the bound runs a scan of
// the slot memory at one slot per cycle, and a pass repeats each time the
// candidate ID runs into the bound. A release walks the slots in order and
// ends at the first match, or after a full pass with status "not found". The
// slot memory's single port sets the scan rate. A finished result sits in an
// output register, so the next request is taken while it waits.
`default_nettype none

module process_id_allocator_core (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [0] opcode, [7:1] release_id
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata    // [6:0] given_id, [8:7] status, [15:9] zero
);
  import pida_pkg::*;

  tbl_req_t        tbl_req;
  logic [ID_W-1:0] tbl_rd_data;
  res_t            res;
  logic            res_ready;

  pida_table u_table (
    .clk     (clk),
    .req     (tbl_req),
    .rd_data (tbl_rd_data)
  );

  pida_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (s_tvalid),
    .req_ready      (s_tready),
    .req_opcode     (s_tdata[0]),
    .req_release_id (s_tdata[7:1]),
    .tbl_req        (tbl_req),
    .tbl_rd_data    (tbl_rd_data),
    .res            (res),
    .res_ready      (res_ready)
  );

  assign res_ready = !m_tvalid || m_tready;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      m_tdata <= {7'd0, res.status, res.given_id};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pida_checker.sv =====
// ---------------------------------------------------------------------------
// pida_checker
// Port-level checks of the process ID allocator, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module pida_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [15:0] m_tdata
);
  import pida_pkg::*;

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Status is always a defined code
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8:7] == ST_OK || m_tdata[8:7] == ST_FULL ||
                  m_tdata[8:7] == ST_MISS))
    else $error("undefined status code");

  // Refused or missed requests return ID zero
  a_fail_id: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8:7] != ST_OK |-> m_tdata[6:0] == '0)
    else $error("failed request returned a nonzero ID");

  // One request at a time: no accept right after an accept
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in progress");

endmodule

bind process_id_allocator_core pida_checker u_pida_checker (.*);

`default_nettype wire
